@@ sv/lsps_pkg.sv @@
// Shared types, constants and the steering weight table of the line sensor PD steering block.
`default_nettype none
package lsps_pkg;

    localparam int LANE_MAX          = 8;
    localparam int FIELD_BITS        = 10;
    localparam int DEF_SENSOR_COUNT  = 8;
    localparam int DEF_SAMPLE_BITS   = 10;
    localparam int COUNT_BITS        = 4;
    localparam int TOP_BITS          = 3;
    localparam int ERR_BITS          = 7;
    localparam int GAIN_BITS         = 6;
    localparam int SPEED_BITS        = 10;
    localparam int CFG_INDEX_BITS    = 8;
    localparam int IN_TDATA_BITS     = 80;
    localparam int OUT_TDATA_BITS    = 40;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_SPEED = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PROP_GAIN  = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DERIV_GAIN = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DUTY_LIMIT = 8'd3;

    localparam logic [SPEED_BITS-1:0] RST_BASE_SPEED = 10'd700;
    localparam logic [GAIN_BITS-1:0]  RST_PROP_GAIN  = 6'd12;
    localparam logic [GAIN_BITS-1:0]  RST_DERIV_GAIN = 6'd30;
    localparam logic [SPEED_BITS-1:0] RST_DUTY_LIMIT = 10'd799;

    localparam logic MODE_CALIBRATE = 1'b0;
    localparam logic MODE_RUN       = 1'b1;

    typedef struct packed {
        logic [SPEED_BITS-1:0] base_speed;
        logic [GAIN_BITS-1:0]  prop_gain;
        logic [GAIN_BITS-1:0]  deriv_gain;
        logic [SPEED_BITS-1:0] duty_limit;
    } t_cfg;

    typedef struct packed {
        logic                  mode;
        logic [LANE_MAX-1:0]   bits;
        logic [COUNT_BITS-1:0] count;
    } t_lane_sum;

    typedef struct packed {
        logic [SPEED_BITS-1:0] right_duty;
        logic                  right_reverse;
        logic [SPEED_BITS-1:0] left_duty;
        logic                  left_reverse;
        logic [LANE_MAX-1:0]   line_bits;
        logic [COUNT_BITS-1:0] black_count;
    } t_result;

    // Steering error in half units; the top channel uses the corrected weight 23.
    function automatic logic signed [ERR_BITS-1:0] weight_halves(input logic [TOP_BITS-1:0] idx);
        logic signed [ERR_BITS-1:0] w;
        unique case (idx)
            3'd0:    w = -7'sd46;
            3'd1:    w = -7'sd16;
            3'd2:    w = -7'sd6;
            3'd3:    w = -7'sd2;
            3'd4:    w = 7'sd2;
            3'd5:    w = 7'sd6;
            3'd6:    w = 7'sd16;
            3'd7:    w = 7'sd46;
            default: w = 7'sd0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

@@ sv/lsps_lane.sv @@
// One sensor lane: calibration window of a channel and its black/white decision.
`default_nettype none
module lsps_lane #(
    parameter int SAMPLE_BITS = lsps_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cal,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic                        o_black
);
    localparam int DW = SAMPLE_BITS + 3;

    logic [SAMPLE_BITS-1:0] r_min;
    logic [SAMPLE_BITS-1:0] r_max;
    logic signed [DW-1:0]   w_span;
    logic signed [DW-1:0]   w_diff2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '1;
            r_max <= '0;
        end else if (i_cal) begin
            if (i_sample > r_max) begin
                r_max <= i_sample;
            end
            if (i_sample < r_min) begin
                r_min <= i_sample;
            end
        end
    end

    always_comb begin
        w_span  = $signed({3'b000, r_max}) - $signed({3'b000, r_min});
        w_diff2 = ($signed({3'b000, i_sample}) - $signed({3'b000, r_min})) <<< 1;
        o_black = (w_span > 0) && (w_diff2 < w_span);
    end

endmodule
`default_nettype wire

@@ sv/lsps_pd.sv @@
// Merge of the lane results: steering error, PD products, wheel drives and output register.
`default_nettype none
module lsps_pd (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lsps_pkg::t_cfg      i_cfg,
    input  wire logic                i_s1_valid,
    input  wire lsps_pkg::t_lane_sum i_s1,
    output logic                     o_s1_ready,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output lsps_pkg::t_result        o_result
);
    localparam int EW = lsps_pkg::ERR_BITS;
    localparam int SW = lsps_pkg::SPEED_BITS;
    localparam int DRV_BITS = 16;

    logic                              r_s2_valid;
    logic                              r_s2_mode;
    logic [lsps_pkg::LANE_MAX-1:0]     r_s2_bits;
    logic [lsps_pkg::COUNT_BITS-1:0]   r_s2_count;
    logic signed [13:0]                r_s2_prod_p;
    logic signed [14:0]                r_s2_prod_d;
    logic signed [EW-1:0]              r_prev_err;
    logic                              r_out_valid;
    lsps_pkg::t_result                 r_out;

    logic                              w_s2_ready;
    logic                              w_out_ready;
    logic [lsps_pkg::TOP_BITS-1:0]     w_top;
    logic signed [EW-1:0]              w_err;
    logic signed [EW:0]                w_derr;
    logic signed [13:0]                w_prod_p;
    logic signed [14:0]                w_prod_d;
    logic signed [DRV_BITS-1:0]        w_p;
    logic signed [DRV_BITS-1:0]        w_base;
    logic signed [DRV_BITS-1:0]        w_right;
    logic signed [DRV_BITS-1:0]        w_left;
    lsps_pkg::t_result                 w_res;

    function automatic logic [SW-1:0] sat_mag(input logic signed [DRV_BITS-1:0] drv,
                                              input logic [SW-1:0] limit);
        logic [DRV_BITS-1:0] mag;
        mag = drv[DRV_BITS-1] ? DRV_BITS'(-drv) : DRV_BITS'(drv);
        return (mag > {{(DRV_BITS-SW){1'b0}}, limit}) ? limit : mag[SW-1:0];
    endfunction

    assign w_out_ready = !r_out_valid || i_ready;
    assign w_s2_ready  = !r_s2_valid || w_out_ready;
    assign o_s1_ready  = w_s2_ready;

    // Error from the highest black lane, halved when exactly two lanes are black.
    always_comb begin
        w_top = '0;
        for (int i = 0; i < lsps_pkg::LANE_MAX; i++) begin
            if (i_s1.bits[i]) begin
                w_top = lsps_pkg::TOP_BITS'(i);
            end
        end
        w_err = (|i_s1.bits) ? lsps_pkg::weight_halves(w_top) : '0;
        if (i_s1.count == lsps_pkg::COUNT_BITS'(2)) begin
            w_err = w_err >>> 1;
        end
        w_derr   = $signed({w_err[EW-1], w_err}) - $signed({r_prev_err[EW-1], r_prev_err});
        w_prod_p = $signed({1'b0, i_cfg.prop_gain}) * w_err;
        w_prod_d = $signed({1'b0, i_cfg.deriv_gain}) * w_derr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_prev_err <= '0;
        end else if (w_s2_ready) begin
            r_s2_valid <= i_s1_valid;
            if (i_s1_valid && (i_s1.mode == lsps_pkg::MODE_RUN)) begin
                r_prev_err <= w_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_ready && i_s1_valid) begin
            r_s2_mode   <= i_s1.mode;
            r_s2_bits   <= i_s1.bits;
            r_s2_count  <= i_s1.count;
            r_s2_prod_p <= w_prod_p;
            r_s2_prod_d <= w_prod_d;
        end
    end

    // Lower one wheel by the PD term; the other keeps base speed.
    always_comb begin
        w_p    = DRV_BITS'(r_s2_prod_p) + DRV_BITS'(r_s2_prod_d);
        w_base = $signed({{(DRV_BITS-SW){1'b0}}, i_cfg.base_speed});
        if (w_p >= 0) begin
            w_left  = w_base;
            w_right = w_base - w_p;
        end else begin
            w_right = w_base;
            w_left  = w_base + w_p;
        end
        if (r_s2_mode == lsps_pkg::MODE_RUN) begin
            w_res.right_duty    = sat_mag(w_right, i_cfg.duty_limit);
            w_res.right_reverse = w_right[DRV_BITS-1];
            w_res.left_duty     = sat_mag(w_left, i_cfg.duty_limit);
            w_res.left_reverse  = w_left[DRV_BITS-1];
            w_res.line_bits     = r_s2_bits;
            w_res.black_count   = r_s2_count;
        end else begin
            w_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_s2_valid) begin
            r_out <= w_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
`default_nettype wire

@@ sv/line_sensor_pd_steering.sv @@
// Line sensor PD steering: lane array, lane summary stage, PD merge and config registers.
//
// Input stream (s side): one request per sensor tick; tuser carries the mode (0 calibrate,
// 1 run), tdata the eight 10-bit samples, sample 0 (leftmost) in the lowest bits.
// Output stream (m side): one result per request, in order: wheel duties, reverse flags,
// line bits and black count. Calibrate requests widen each channel's min/max window and
// return an all-zero result.
// Config channel: index 0 base_speed, 1 prop_gain, 2 deriv_gain, 3 duty_limit; other
// indexes are dropped. Always ready; write only while no request is in flight.
// Path: an accepted request passes the three register stages (lane summary, PD products,
// output) before its result shows valid; the lanes classify in parallel.
// Throughput: one request per cycle while the receiver keeps tready high.
// Stall: when the receiver holds tready low the stages fill up behind the output
// register, and s_tready drops only when all three stages hold a request.
// Reset: duties flow again right away; config registers return to 700/12/30/799, channel
// windows to empty (min all ones, max zero) so channels read white until calibrated,
// and the previous steering error to zero.
`default_nettype none
module line_sensor_pd_steering #(
    parameter int SENSOR_COUNT = lsps_pkg::DEF_SENSOR_COUNT,
    parameter int SAMPLE_BITS  = lsps_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // tdata: sample_0 .. sample_7, 10 bits each
    input  wire logic [lsps_pkg::IN_TDATA_BITS-1:0]  i_s_tdata,
    // tuser: mode
    input  wire logic                                i_s_tuser,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // tdata: right_duty[9:0], right_reverse, left_duty[9:0], left_reverse,
    //        line_bits[7:0], black_count[3:0], zero fill
    output logic [lsps_pkg::OUT_TDATA_BITS-1:0]      o_m_tdata,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [lsps_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [lsps_pkg::SPEED_BITS-1:0]     i_cfg_data
);
    localparam int FB = lsps_pkg::FIELD_BITS;

    lsps_pkg::t_cfg                r_cfg;
    logic                          r_s1_valid;
    lsps_pkg::t_lane_sum           r_s1;
    logic [lsps_pkg::LANE_MAX-1:0] w_black;
    logic                          w_s1_ready;
    logic                          w_s2_ready;
    logic                          w_accept;
    logic                          w_cal;
    lsps_pkg::t_result             w_res;

    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign o_s_tready = w_s1_ready;
    assign w_accept   = i_s_tvalid && w_s1_ready;
    assign w_cal      = w_accept && (i_s_tuser == lsps_pkg::MODE_CALIBRATE);

    genvar g;
    generate
        for (g = 0; g < lsps_pkg::LANE_MAX; g++) begin : g_lane
            if (g < SENSOR_COUNT) begin : g_on
                lsps_lane #(
                    .SAMPLE_BITS (SAMPLE_BITS)
                ) u_lane (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_cal    (w_cal),
                    .i_sample (SAMPLE_BITS'(i_s_tdata[g*FB +: FB])),
                    .o_black  (w_black[g])
                );
            end else begin : g_off
                assign w_black[g] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1.mode  <= i_s_tuser;
            r_s1.bits  <= w_black;
            r_s1.count <= lsps_pkg::COUNT_BITS'($countones(w_black));
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_speed <= lsps_pkg::RST_BASE_SPEED;
            r_cfg.prop_gain  <= lsps_pkg::RST_PROP_GAIN;
            r_cfg.deriv_gain <= lsps_pkg::RST_DERIV_GAIN;
            r_cfg.duty_limit <= lsps_pkg::RST_DUTY_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lsps_pkg::CFG_BASE_SPEED: r_cfg.base_speed <= i_cfg_data;
                lsps_pkg::CFG_PROP_GAIN:  r_cfg.prop_gain  <= i_cfg_data[lsps_pkg::GAIN_BITS-1:0];
                lsps_pkg::CFG_DERIV_GAIN: r_cfg.deriv_gain <= i_cfg_data[lsps_pkg::GAIN_BITS-1:0];
                lsps_pkg::CFG_DUTY_LIMIT: r_cfg.duty_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lsps_pd u_pd (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s1_valid (r_s1_valid),
        .i_s1       (r_s1),
        .o_s1_ready (w_s2_ready),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_result   (w_res)
    );

    assign o_m_tdata = {6'b000000, w_res.black_count, w_res.line_bits, w_res.left_reverse,
                        w_res.left_duty, w_res.right_reverse, w_res.right_duty};

endmodule
`default_nettype wire
